// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/s2a_pkg.sv -----
// package: scan code constants, decode struct and layout tables
package s2a_pkg;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned KEY_W   = 7;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned ENTRY_W = 8;

    localparam logic [KEY_W-1:0] LSHIFT_KEY = 7'd42;
    localparam logic [KEY_W-1:0] RSHIFT_KEY = 7'd54;

    typedef struct packed {
        logic              emit;
        logic [CHAR_W-1:0] ascii;
        logic              shift_nxt;
        logic [KEY_W-1:0]  last_nxt;
    } t_dec;

    // layout table; most rows give a shifted and an unshifted entry, the rest share one
    function automatic logic [ENTRY_W-1:0] layout_entry(input logic [KEY_W-1:0] key,
                                                        input logic shift);
        logic [ENTRY_W-1:0] e;
        e = 8'h00;
        case (key)
            7'h01: e = 8'h1B;
            7'h02: e = shift ? 8'h21 : 8'h31;
            7'h03: e = shift ? 8'h40 : 8'h32;
            7'h04: e = shift ? 8'h23 : 8'h33;
            7'h05: e = shift ? 8'h24 : 8'h34;
            7'h06: e = shift ? 8'h25 : 8'h35;
            7'h07: e = shift ? 8'h5E : 8'h36;
            7'h08: e = shift ? 8'h26 : 8'h37;
            7'h09: e = shift ? 8'h2A : 8'h38;
            7'h0A: e = shift ? 8'h28 : 8'h39;
            7'h0B: e = shift ? 8'h29 : 8'h30;
            7'h0C: e = shift ? 8'h5F : 8'h2D;
            7'h0D: e = shift ? 8'h2B : 8'h3D;
            7'h0E: e = 8'h7F;
            7'h0F: e = 8'h09;
            7'h10: e = shift ? 8'h51 : 8'h71;
            7'h11: e = shift ? 8'h57 : 8'h77;
            7'h12: e = shift ? 8'h45 : 8'h65;
            7'h13: e = shift ? 8'h52 : 8'h72;
            7'h14: e = shift ? 8'h54 : 8'h74;
            7'h15: e = shift ? 8'h59 : 8'h79;
            7'h16: e = shift ? 8'h55 : 8'h75;
            7'h17: e = shift ? 8'h49 : 8'h69;
            7'h18: e = shift ? 8'h4F : 8'h6F;
            7'h19: e = shift ? 8'h50 : 8'h70;
            7'h1A: e = shift ? 8'h7B : 8'h5B;
            7'h1B: e = shift ? 8'h7D : 8'h5D;
            7'h1C: e = 8'h0D;
            7'h1E: e = shift ? 8'h41 : 8'h61;
            7'h1F: e = shift ? 8'h53 : 8'h73;
            7'h20: e = shift ? 8'h44 : 8'h64;
            7'h21: e = shift ? 8'h46 : 8'h66;
            7'h22: e = shift ? 8'h47 : 8'h67;
            7'h23: e = shift ? 8'h48 : 8'h68;
            7'h24: e = shift ? 8'h4A : 8'h6A;
            7'h25: e = shift ? 8'h4B : 8'h6B;
            7'h26: e = shift ? 8'h4C : 8'h6C;
            7'h27: e = shift ? 8'h3A : 8'h3B;
            7'h28: e = shift ? 8'h22 : 8'h27;
            7'h29: e = 8'h60;
            7'h2B: e = 8'h5C;
            7'h2C: e = shift ? 8'h5A : 8'h7A;
            7'h2D: e = shift ? 8'h58 : 8'h78;
            7'h2E: e = shift ? 8'h43 : 8'h63;
            7'h2F: e = shift ? 8'h56 : 8'h76;
            7'h30: e = shift ? 8'h42 : 8'h62;
            7'h31: e = shift ? 8'h4E : 8'h6E;
            7'h32: e = shift ? 8'h4D : 8'h6D;
            7'h33: e = shift ? 8'h3C : 8'h2C;
            7'h34: e = shift ? 8'h3E : 8'h2E;
            7'h35: e = shift ? 8'h3F : 8'h2F;
            7'h37: e = 8'h2A;
            7'h39: e = 8'h20;
            7'h3B: e = 8'h81;
            7'h3C: e = 8'h82;
            7'h3D: e = 8'h83;
            7'h3E: e = 8'h84;
            7'h3F: e = 8'h85;
            7'h40: e = 8'h86;
            7'h41: e = 8'h87;
            7'h42: e = 8'h88;
            7'h43: e = 8'h89;
            7'h44: e = 8'h8A;
            7'h47: e = 8'h37;
            7'h48: e = 8'h38;
            7'h49: e = 8'h39;
            7'h4A: e = 8'h2D;
            7'h4B: e = 8'h34;
            7'h4C: e = 8'h35;
            7'h4D: e = 8'h36;
            7'h4E: e = 8'h2B;
            7'h4F: e = 8'h31;
            7'h50: e = 8'h32;
            7'h51: e = 8'h33;
            7'h52: e = 8'h30;
            7'h53: e = 8'h7F;
            7'h56: e = 8'h8B;
            7'h57: e = 8'h8C;
            7'h62: e = 8'h0D;
            7'h64: e = 8'h2F;
            default: e = 8'h00;
        endcase
        return e;
    endfunction

endpackage

// ----- hw/rtl/s2a_if.sv -----
// stream interfaces for scan code input and character output
interface s2a_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

interface s2a_ascii_if;
    logic       valid;
    logic       ready;
    logic [6:0] ascii_char;

    modport source (output valid, output ascii_char, input ready);
    modport sink   (input valid, input ascii_char, output ready);
endinterface

// ----- hw/rtl/s2a_decode.sv -----
// decode of one scan code against the shift and last-key state
module s2a_decode (
    input  logic [s2a_pkg::CODE_W-1:0] i_code,
    input  logic                       i_shift,
    input  logic [s2a_pkg::KEY_W-1:0]  i_last,
    output s2a_pkg::t_dec              o_dec
);
    import s2a_pkg::*;

    logic [KEY_W-1:0]   w_key;
    logic               w_release;
    logic               w_is_shift;
    logic [ENTRY_W-1:0] w_entry;

    assign w_key      = i_code[KEY_W-1:0];
    assign w_release  = i_code[CODE_W-1];
    assign w_is_shift = (w_key == LSHIFT_KEY) || (w_key == RSHIFT_KEY);
    assign w_entry    = layout_entry(w_key, i_shift);

    always_comb begin
        o_dec.emit      = 1'b0;
        o_dec.ascii     = w_entry[CHAR_W-1:0];
        o_dec.shift_nxt = i_shift;
        o_dec.last_nxt  = i_last;
        if (w_is_shift) begin
            o_dec.shift_nxt = ~w_release;
        end else if (w_release) begin
            o_dec.last_nxt = '0;
        end else if (w_key != i_last) begin
            // fresh press; codes above the ascii range are dropped
            o_dec.last_nxt = w_key;
            o_dec.emit     = (w_entry != '0) && !w_entry[ENTRY_W-1];
        end
    end

endmodule

// ----- hw/rtl/scancode_to_ascii_decoder_top.sv -----
// top level: set 1 scan code to ascii decoder with registered stream ports
// Takes one scan code byte per transfer and returns at most one 7-bit character per byte.
// A byte is accepted in every clock cycle unless the input register holds a stalled one;
// it is captured in that input register, decoded against the shift and last-key state by
// one table lookup, and the character lands in the result register that drives the port.
// Shift make/break, other releases, auto-repeats and keys with no printable entry give
// no character. The result register lets the next byte in while a character waits; only
// a byte that would give a character is held in the input register behind a stalled one.
`include "assert_macros.svh"

module scancode_to_ascii_decoder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    s2a_scan_if.sink          i_scan,
    s2a_ascii_if.source       o_ascii
);
    import s2a_pkg::*;

    logic              r_in_vld;
    logic              n_in_vld;
    logic [CODE_W-1:0] r_code;
    logic              r_shift;
    logic              n_shift;
    logic [KEY_W-1:0]  r_last;
    logic [KEY_W-1:0]  n_last;
    logic              r_out_vld;
    logic              n_out_vld;
    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] n_char;
    logic              w_adv;
    logic              w_in_rdy;
    t_dec              w_dec;

    s2a_decode u_decode (
        .i_code  (r_code),
        .i_shift (r_shift),
        .i_last  (r_last),
        .o_dec   (w_dec)
    );

    // stage moves on unless a character would overwrite a stalled one
    assign w_adv    = r_in_vld && (!w_dec.emit || !r_out_vld || o_ascii.ready);
    assign w_in_rdy = !r_in_vld || w_adv;

    assign i_scan.ready       = w_in_rdy;
    assign o_ascii.valid      = r_out_vld;
    assign o_ascii.ascii_char = r_char;

    always_comb begin
        n_in_vld  = r_in_vld;
        n_shift   = r_shift;
        n_last    = r_last;
        n_out_vld = r_out_vld;
        n_char    = r_char;
        if (w_adv) begin
            n_in_vld = 1'b0;
            n_shift  = w_dec.shift_nxt;
            n_last   = w_dec.last_nxt;
        end
        if (i_scan.valid && w_in_rdy) begin
            n_in_vld = 1'b1;
        end
        if (r_out_vld && o_ascii.ready) begin
            n_out_vld = 1'b0;
        end
        if (w_adv && w_dec.emit) begin
            n_out_vld = 1'b1;
            n_char    = w_dec.ascii;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_shift   <= 1'b0;
            r_last    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_shift   <= n_shift;
            r_last    <= n_last;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.valid && w_in_rdy) begin
            r_code <= i_scan.scan_code;
        end
        r_char <= n_char;
    end

    `ASSERT_IMP(a_char_nonzero, i_clk, i_rst_n, r_out_vld, r_char != '0)
    `ASSERT_IMP(a_state_after_reset, i_clk, i_rst_n, !$past(i_rst_n),
                !r_shift && r_last == '0 && !r_in_vld && !r_out_vld)
    `ASSERT_NXT(a_emit_is_fresh_key, i_clk, i_rst_n, w_adv && w_dec.emit,
                r_out_vld && r_last == $past(r_code[KEY_W-1:0]))
    `ASSERT_NXT(a_stalled_byte_held, i_clk, i_rst_n, r_in_vld && !w_adv,
                r_in_vld && $stable(r_code))

endmodule
